/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the scheduler RTL.
// Both macros assume a clock named clk; ECS_ASSERT also assumes an active-low reset named rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge outside of reset.
`define ECS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define ECS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ECS_ASSERT(lbl, prop, msg)
`define ECS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/ecs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecs_pkg
// Types and constants of the elevator call scheduler.
// ----------------------------------------------------------------------------
package ecs_pkg;

    localparam int NUM_FLOORS_DEF = 16;
    localparam int FLOOR_W        = 5;
    localparam int MODE_W         = 2;
    localparam int DIR_W          = 2;

    localparam logic [MODE_W-1:0] MODE_PRESS  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ARRIVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PASS   = 2'd2;

    localparam logic [DIR_W-1:0] DIR_UP = 2'd0;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } ecs_state_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_PRESS,
        ACT_ARRIVE
    } ecs_act_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [FLOOR_W-1:0] floor;
        logic [DIR_W-1:0]   direction;
    } ecs_evt_beat_t;

    typedef struct packed {
        logic               call_valid;
        logic [FLOOR_W-1:0] call_floor;
        logic               new_request;
        logic               busy_res;
    } ecs_rsp_beat_t;

    typedef struct packed {
        logic set;
        logic clr;
        logic at_start;
    } ecs_cell_ctrl_t;

    typedef struct packed {
        logic req;
        logic hit_up;
        logic hit_dn;
    } ecs_cell_stat_t;

endpackage

/* rtl/ecs_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecs_cell
// One floor: holds the request bit and passes the scan tokens to its neighbors.
// ----------------------------------------------------------------------------
module ecs_cell
    import ecs_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  ecs_cell_ctrl_t ctrl,
    input  logic           up_in,
    input  logic           dn_in,
    output logic           up_out,
    output logic           dn_out,
    output ecs_cell_stat_t stat
);

    logic req_reg;
    logic req_next;
    logic scan_up;
    logic scan_dn;

    always_comb
    begin
        req_next = req_reg;
        if (ctrl.set)
        begin
            req_next = 1'b1;
        end
        else if (ctrl.clr)
        begin
            req_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg <= 1'b0;
        end
        else
        begin
            req_reg <= req_next;
        end
    end

    // Token travels on until the first requested floor absorbs it.
    assign scan_up     = up_in | ctrl.at_start;
    assign scan_dn     = dn_in | ctrl.at_start;
    assign up_out      = scan_up & ~req_reg;
    assign dn_out      = scan_dn & ~req_reg;
    assign stat.req    = req_reg;
    assign stat.hit_up = scan_up & req_reg;
    assign stat.hit_dn = scan_dn & req_reg;

endmodule

/* rtl/ecs_cell_row.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecs_cell_row
// Row of floor cells with upward and downward scan chains and hit encoders.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ecs_cell_row
    import ecs_pkg::*;
#(
    parameter int NUM_FLOORS = NUM_FLOORS_DEF,
    localparam int IDX_W     = $clog2(NUM_FLOORS)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  set_en,
    input  logic                  clr_en,
    input  logic [IDX_W-1:0]      wr_idx,
    input  logic [IDX_W-1:0]      start_idx,
    output logic [NUM_FLOORS-1:0] req_map,
    output logic                  found_up,
    output logic [IDX_W-1:0]      up_idx,
    output logic                  found_dn,
    output logic [IDX_W-1:0]      dn_idx
);

    logic [NUM_FLOORS:0]   up_chain;
    logic [NUM_FLOORS:0]   dn_chain;
    logic [NUM_FLOORS-1:0] hit_up;
    logic [NUM_FLOORS-1:0] hit_dn;

    assign up_chain[0]          = 1'b0;
    assign dn_chain[NUM_FLOORS] = 1'b0;

    for (genvar g = 0; g < NUM_FLOORS; g++)
    begin : g_cell
        ecs_cell_ctrl_t ctrl;
        ecs_cell_stat_t stat;

        assign ctrl.set      = set_en && (wr_idx == IDX_W'(g));
        assign ctrl.clr      = clr_en && (wr_idx == IDX_W'(g));
        assign ctrl.at_start = (start_idx == IDX_W'(g));

        ecs_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .up_in  (up_chain[g]),
            .dn_in  (dn_chain[g+1]),
            .up_out (up_chain[g+1]),
            .dn_out (dn_chain[g]),
            .stat   (stat)
        );

        assign req_map[g] = stat.req;
        assign hit_up[g]  = stat.hit_up;
        assign hit_dn[g]  = stat.hit_dn;
    end

    // A token that leaves the end of the row found nothing.
    assign found_up = ~up_chain[NUM_FLOORS];
    assign found_dn = ~dn_chain[0];

    always_comb
    begin
        up_idx = '0;
        dn_idx = '0;
        for (int i = 0; i < NUM_FLOORS; i++)
        begin
            if (hit_up[i])
            begin
                up_idx = up_idx | IDX_W'(i);
            end
            if (hit_dn[i])
            begin
                dn_idx = dn_idx | IDX_W'(i);
            end
        end
    end

    `ECS_ASSERT_ALWAYS(a_hit_up_onehot, $onehot0(hit_up), "several upward hits")
    `ECS_ASSERT_ALWAYS(a_hit_dn_onehot, $onehot0(hit_dn), "several downward hits")

endmodule

/* rtl/elevator_call_scheduler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_call_scheduler_top
// SCAN call scheduler for one car: floor requests, position, direction, busy.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake            | Beat
//  evt     | in  | evt_valid/evt_stall  | ecs_evt_beat_t: mode, floor, direction
//  rsp     | out | rsp_valid/rsp_stall  | ecs_rsp_beat_t: call, new request, busy
//
//  Every event runs in order through the accept in ST_IDLE, which updates the request
//  cells, position and direction, and ST_SEARCH, which runs the cell-chain scan and
//  loads the result register. The scan ripples through one cell per floor.
//  A result waiting under rsp_stall does not block the next accept; the scan
//  cycle is held until the result register is free.
//  Reset (async, rst_n low): no requests, floor 1, direction not up, car free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module elevator_call_scheduler_top
    import ecs_pkg::*;
#(
    parameter int NUM_FLOORS = NUM_FLOORS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          evt_valid,
    output logic          evt_stall,
    input  ecs_evt_beat_t evt_beat,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ecs_rsp_beat_t rsp_beat
);

    localparam int IDX_W = $clog2(NUM_FLOORS);
    localparam logic [FLOOR_W:0] FLOOR_MAX = (FLOOR_W+1)'(NUM_FLOORS);

    ecs_state_t          state_reg, state_next;
    ecs_act_t            act_reg, act_next;
    logic [IDX_W-1:0]    cur_idx_reg, cur_idx_next;
    logic                dir_up_reg, dir_up_next;
    logic                busy_reg, busy_next;
    logic                out_valid_reg, out_valid_next;
    ecs_rsp_beat_t       out_beat_reg, out_beat_next;

    logic                evt_accept;
    logic                floor_ok;
    logic [FLOOR_W-1:0]  floor_m1;
    logic [IDX_W-1:0]    wr_idx;
    logic                set_en;
    logic                clr_en;
    logic [NUM_FLOORS-1:0] req_map;
    logic                found_up;
    logic                found_dn;
    logic [IDX_W-1:0]    up_idx;
    logic [IDX_W-1:0]    dn_idx;
    logic                found;
    logic [IDX_W-1:0]    tgt_idx;
    logic [FLOOR_W:0]    tgt_sum;
    logic                out_free;

    // ------------------------------------------------------------------
    // Event decode
    // ------------------------------------------------------------------
    assign evt_stall  = (state_reg != ST_IDLE);
    assign evt_accept = evt_valid && !evt_stall;
    assign floor_ok   = (evt_beat.floor != '0) && ({1'b0, evt_beat.floor} <= FLOOR_MAX);
    assign floor_m1   = evt_beat.floor - FLOOR_W'(1);
    assign wr_idx     = floor_m1[IDX_W-1:0];

    // ------------------------------------------------------------------
    // Floor cells: request bits and scan chains
    // ------------------------------------------------------------------
    ecs_cell_row #(
        .NUM_FLOORS (NUM_FLOORS)
    ) u_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .set_en    (set_en),
        .clr_en    (clr_en),
        .wr_idx    (wr_idx),
        .start_idx (cur_idx_reg),
        .req_map   (req_map),
        .found_up  (found_up),
        .up_idx    (up_idx),
        .found_dn  (found_dn),
        .dn_idx    (dn_idx)
    );

    // Scan the travel direction first; moving up scans up, anything else down.
    assign found   = found_up | found_dn;
    assign tgt_idx = dir_up_reg ? (found_up ? up_idx : dn_idx)
                                : (found_dn ? dn_idx : up_idx);
    assign tgt_sum = (FLOOR_W+1)'(tgt_idx) + (FLOOR_W+1)'(1);

    assign out_free = !out_valid_reg || !rsp_stall;

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        cur_idx_next   = cur_idx_reg;
        dir_up_next    = dir_up_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_beat_next  = out_beat_reg;
        set_en         = 1'b0;
        clr_en         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt_accept)
                begin
                    act_next   = ACT_NONE;
                    state_next = ST_SEARCH;
                    if (floor_ok)
                    begin
                        unique case (evt_beat.mode)
                            MODE_PRESS:
                            begin
                                busy_next = 1'b1;
                                if (!req_map[wr_idx])
                                begin
                                    set_en   = 1'b1;
                                    act_next = ACT_PRESS;
                                end
                            end
                            MODE_ARRIVE:
                            begin
                                if (busy_reg)
                                begin
                                    cur_idx_next = wr_idx;
                                    dir_up_next  = (evt_beat.direction == DIR_UP);
                                    clr_en       = 1'b1;
                                    act_next     = ACT_ARRIVE;
                                end
                            end
                            MODE_PASS:
                            begin
                                cur_idx_next = wr_idx;
                                dir_up_next  = (evt_beat.direction == DIR_UP);
                            end
                            default:
                            begin
                                act_next = ACT_NONE;
                            end
                        endcase
                    end
                end
            end
            ST_SEARCH:
            begin
                // Hold the scan result until the output register frees up.
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_beat_next.call_valid  = 1'b0;
                    out_beat_next.call_floor  = '0;
                    out_beat_next.new_request = 1'b0;
                    out_beat_next.busy_res    = busy_reg;
                    unique case (act_reg)
                        ACT_PRESS:
                        begin
                            out_beat_next.call_valid  = 1'b1;
                            out_beat_next.call_floor  = tgt_sum[FLOOR_W-1:0];
                            out_beat_next.new_request = 1'b1;
                        end
                        ACT_ARRIVE:
                        begin
                            if (found)
                            begin
                                out_beat_next.call_valid = 1'b1;
                                out_beat_next.call_floor = tgt_sum[FLOOR_W-1:0];
                            end
                            else
                            begin
                                busy_next              = 1'b0;
                                out_beat_next.busy_res = 1'b0;
                            end
                        end
                        default:
                        begin
                            out_beat_next.call_valid = 1'b0;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            act_reg       <= ACT_NONE;
            cur_idx_reg   <= '0;
            dir_up_reg    <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            cur_idx_reg   <= cur_idx_next;
            dir_up_reg    <= dir_up_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_beat  = out_beat_reg;

    `ECS_ASSERT(a_accept_to_search, evt_accept |=> (state_reg == ST_SEARCH), "accept not followed by scan")
    `ECS_ASSERT(a_new_req_calls, (rsp_valid && rsp_beat.new_request) |-> (rsp_beat.call_valid && rsp_beat.busy_res), "new request without call")
    `ECS_ASSERT(a_call_floor_set, (rsp_valid && rsp_beat.call_valid) |-> (rsp_beat.call_floor != '0), "call to floor zero")
    `ECS_ASSERT(a_idle_floor_zero, (rsp_valid && !rsp_beat.call_valid) |-> (rsp_beat.call_floor == '0), "floor without call")

endmodule
